// ===== rtl/core/sgs_pkg.sv =====
// Shared constants, item type and register codes for the Sobel gradient stream.
package sgs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIXEL_BITS = 8;

  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  // Register and dimension width fixed by the register map.
  localparam int DIM_BITS   = 11;
  localparam int DIM_MIN    = 3;
  localparam int DIM_RESET  = 512;

  localparam int CFG_INDEX_BITS = 4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

  // Gradient: difference of two weighted sums of three pixels each, weights 1, 2, 1.
  localparam int GRAD_BITS  = PIXEL_BITS + 3;
  localparam int SQ_BITS    = 2 * GRAD_BITS - 1;
  localparam int ROOT_BITS  = GRAD_BITS;
  localparam int RES_BITS   = SQ_BITS + 1;

  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [GRAD_BITS-1:0] grad_x;
    logic signed [GRAD_BITS-1:0] grad_y;
    logic [ROW_BITS-1:0]         center_row;
    logic [COL_BITS-1:0]         center_col;
    logic                        last_of_frame;
  } sgs_item_t;

endpackage

// ===== rtl/core/sgs_front.sv =====
// Front end: pixel counters, border padding, line store, 3x3 window and gradients.
module sgs_front import sgs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [PIXEL_BITS-1:0] pixel,
  input  logic [DIM_BITS-1:0]   frame_width,
  input  logic [DIM_BITS-1:0]   frame_height,
  output logic                  q_push,
  output sgs_item_t             q_item
);

  logic [COL_BITS-1:0] col, col_next;
  logic [ROW_BITS-1:0] row, row_next;
  logic [DIM_BITS-1:0] col_ext, row_ext, col_inc, row_inc;
  logic                border, produce, last_pix;
  logic [PIXEL_BITS-1:0] pix_pad;

  logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
  logic [2*PIXEL_BITS-1:0] rd_data;

  logic                  s1_valid;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic [COL_BITS-1:0]   s1_col;
  logic                  s1_produce;
  logic                  s1_last;
  logic [ROW_BITS-1:0]   s1_row_out;
  logic [COL_BITS-1:0]   s1_col_out;

  logic [PIXEL_BITS-1:0] win_tl, win_ml, win_bl, win_tc, win_mc, win_bc;
  logic [PIXEL_BITS-1:0] top_right, mid_right;
  logic [GRAD_BITS-1:0]  sum_right, sum_left, sum_bottom, sum_top;

  assign col_ext = DIM_BITS'(col);
  assign row_ext = DIM_BITS'(row);
  assign col_inc = col_ext + DIM_BITS'(1);
  assign row_inc = row_ext + DIM_BITS'(1);

  assign border   = (row == '0) || (row_inc >= frame_height) ||
                    (col == '0) || (col_inc >= frame_width);
  assign produce  = (row_ext >= DIM_BITS'(2)) && (col_ext >= DIM_BITS'(2)) &&
                    (row_ext < frame_height) && (col_ext < frame_width);
  assign last_pix = (row_inc == frame_height) && (col_inc == frame_width);
  assign pix_pad  = border ? '0 : pixel;

  always_comb begin
    col_next = col_inc[COL_BITS-1:0];
    row_next = row;
    if (col_inc >= frame_width) begin
      col_next = '0;
      row_next = (row_inc >= frame_height) ? '0 : row_inc[ROW_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix     <= pix_pad;
      s1_col     <= col;
      s1_produce <= produce;
      s1_last    <= last_pix;
      s1_row_out <= row - ROW_BITS'(1);
      s1_col_out <= col - COL_BITS'(1);
    end
  end

  // Upper row in the high half, middle row in the low half.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= line_mem[col];
    end
    if (s1_valid) begin
      line_mem[s1_col] <= {mid_right, s1_pix};
    end
  end

  assign top_right = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mid_right = rd_data[PIXEL_BITS-1:0];

  // Advance the window by one column per pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_tl <= '0;
      win_ml <= '0;
      win_bl <= '0;
      win_tc <= '0;
      win_mc <= '0;
      win_bc <= '0;
    end else if (s1_valid) begin
      win_tl <= win_tc;
      win_ml <= win_mc;
      win_bl <= win_bc;
      win_tc <= top_right;
      win_mc <= mid_right;
      win_bc <= s1_pix;
    end
  end

  assign sum_right  = GRAD_BITS'(top_right) + (GRAD_BITS'(mid_right) << 1) + GRAD_BITS'(s1_pix);
  assign sum_left   = GRAD_BITS'(win_tl) + (GRAD_BITS'(win_ml) << 1) + GRAD_BITS'(win_bl);
  assign sum_bottom = GRAD_BITS'(win_bl) + (GRAD_BITS'(win_bc) << 1) + GRAD_BITS'(s1_pix);
  assign sum_top    = GRAD_BITS'(win_tl) + (GRAD_BITS'(win_tc) << 1) + GRAD_BITS'(top_right);

  assign q_push = s1_valid && s1_produce;

  always_comb begin
    q_item.grad_x        = $signed(sum_right - sum_left);
    q_item.grad_y        = $signed(sum_bottom - sum_top);
    q_item.center_row    = s1_row_out;
    q_item.center_col    = s1_col_out;
    q_item.last_of_frame = s1_last;
  end

  a_push_follows_accept: assert property (@(posedge clk) disable iff (rst)
    q_push |-> $past(accept))
    else $error("gradient item pushed without an accepted pixel");

endmodule

// ===== rtl/core/sgs_queue.sv =====
// Short item queue between the gradient front end and the magnitude back end.
module sgs_queue import sgs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sgs_item_t            push_item,
  input  logic                 pop,
  output sgs_item_t            head_item,
  output logic                 q_empty,
  output logic [QCNT_BITS-1:0] count
);

  sgs_item_t            slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic                 do_pop;

  assign q_empty   = (count == '0);
  assign do_pop    = pop && !q_empty;
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      count <= count + QCNT_BITS'(push) - QCNT_BITS'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != QCNT_BITS'(QDEPTH)) || do_pop)
    else $error("queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QDEPTH))
    else $error("queue count out of range");

endmodule

// ===== rtl/core/sgs_back.sv =====
// Back end: squares the gradients, takes an iterative square root, holds the result.
module sgs_back import sgs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  sgs_item_t             head_item,
  output logic                  q_pop,
  input  logic                  pop,
  output logic                  empty,
  output logic [GRAD_BITS-1:0]  grad_x,
  output logic [GRAD_BITS-1:0]  grad_y,
  output logic [ROOT_BITS-1:0]  magnitude,
  output logic [ROW_BITS-1:0]   center_row,
  output logic [COL_BITS-1:0]   center_col,
  output logic                  last_of_frame
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state;
  sgs_item_t   work;
  logic [SQ_BITS-1:0]  rem;
  logic [RES_BITS-1:0] res, sq_bit, trial;
  logic signed [2*GRAD_BITS-1:0] sq_x, sq_y, sq_sum;
  logic        out_valid, out_take, out_load;

  assign sq_x   = (2*GRAD_BITS)'(head_item.grad_x) * (2*GRAD_BITS)'(head_item.grad_x);
  assign sq_y   = (2*GRAD_BITS)'(head_item.grad_y) * (2*GRAD_BITS)'(head_item.grad_y);
  assign sq_sum = sq_x + sq_y;
  assign trial  = res + sq_bit;

  assign q_pop    = (state == ST_LOAD) && !q_empty;
  assign out_take = pop && out_valid;
  assign out_load = (state == ST_DONE) && (!out_valid || out_take);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      unique case (state)
        ST_LOAD: if (!q_empty) state <= ST_CALC;
        ST_CALC: if (sq_bit[0]) state <= ST_DONE;
        ST_DONE: if (out_load) state <= ST_LOAD;
        default: state <= ST_LOAD;
      endcase
    end
  end

  // One result bit per cycle: subtract the trial value when it fits.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      work   <= head_item;
      rem    <= sq_sum[SQ_BITS-1:0];
      res    <= '0;
      sq_bit <= RES_BITS'(1) << (2 * (ROOT_BITS - 1));
    end else if (state == ST_CALC) begin
      if (RES_BITS'(rem) >= trial) begin
        rem <= rem - trial[SQ_BITS-1:0];
        res <= (res >> 1) + sq_bit;
      end else begin
        res <= res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      grad_x        <= work.grad_x;
      grad_y        <= work.grad_y;
      magnitude     <= res[ROOT_BITS-1:0];
      center_row    <= work.center_row;
      center_col    <= work.center_col;
      last_of_frame <= work.last_of_frame;
    end
  end

  a_bit_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) |-> $onehot(sq_bit))
    else $error("square root step marker lost");

  a_pop_only_when_loading: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == ST_CALC))
    else $error("queue popped outside the load step");

endmodule

// ===== rtl/core/sobel_gradient_stream_top.sv =====
// Top level: configuration registers, input and output queue ports, front/back wiring.
// Path: a pixel that yields a result goes through the line store read and the window
// into the queue, then a load step, 11 root steps and a hold step that waits on the output.
// Pixels enter one per cycle while the 4-entry queue has room; the back end's
// bit-serial square root takes a new item only after the current one is through.
// Reset: counters, window and queues clear; frame size returns to 512 x 512;
// the line store is not cleared and needs no clearing pass.
module sobel_gradient_stream_top import sgs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [PIXEL_BITS-1:0]     pixel,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [GRAD_BITS-1:0] grad_x,
  output logic signed [GRAD_BITS-1:0] grad_y,
  output logic [ROOT_BITS-1:0]      magnitude,
  output logic [ROW_BITS-1:0]       center_row,
  output logic [COL_BITS-1:0]       center_col,
  output logic                      last_of_frame,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]       cfg_data
);

  logic [DIM_BITS-1:0]  frame_width, frame_height;
  logic                 accept, q_push, q_pop, q_empty;
  sgs_item_t            q_item, head_item;
  logic [QCNT_BITS-1:0] q_count;
  logic [GRAD_BITS-1:0] grad_x_raw, grad_y_raw;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] value,
                                                    input logic [DIM_BITS-1:0] max_dim);
    logic [DIM_BITS-1:0] result;
    result = value;
    if (value < DIM_BITS'(DIM_MIN)) begin
      result = DIM_BITS'(DIM_MIN);
    end else if (value > max_dim) begin
      result = max_dim;
    end
    return result;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_BITS'(DIM_RESET);
      frame_height <= DIM_BITS'(DIM_RESET);
    end else if (cfg_valid) begin
      priority if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= clamp_dim(cfg_data, DIM_BITS'(MAX_WIDTH));
      end else if (cfg_index == REG_FRAME_HEIGHT) begin
        frame_height <= clamp_dim(cfg_data, DIM_BITS'(MAX_HEIGHT));
      end else begin
        // Drop writes beyond the register list.
      end
    end
  end

  // Hold off input when the queue could not take the item now in flight plus one more.
  assign full   = (q_count + QCNT_BITS'(q_push)) >= QCNT_BITS'(QDEPTH);
  assign accept = push && !full;

  sgs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .pixel        (pixel),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  sgs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head_item (head_item),
    .q_empty   (q_empty),
    .count     (q_count)
  );

  sgs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .head_item     (head_item),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .grad_x        (grad_x_raw),
    .grad_y        (grad_y_raw),
    .magnitude     (magnitude),
    .center_row    (center_row),
    .center_col    (center_col),
    .last_of_frame (last_of_frame)
  );

  assign grad_x = $signed(grad_x_raw);
  assign grad_y = $signed(grad_y_raw);

endmodule
